@@ rtl/hrhe_pkg.sv @@
// ----------------------------------------------------------------------------
// hrhe_pkg
// Shared types, character constants, marker tables and result codes for the
// HTTP response header extractor.
// ----------------------------------------------------------------------------
package hrhe_pkg;

   // Characters with a meaning of their own in the header text
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_H     = 8'h48;
   localparam logic [7:0] CHAR_C     = 8'h43;

   // Last position of each marker
   localparam logic [1:0] HTTP_LAST_POS   = 2'd3;
   localparam logic [3:0] LENGTH_LAST_POS = 4'd15;
   localparam logic [3:0] TYPE_LAST_POS   = 4'd13;

   // Reset value of the accepted status code
   localparam logic [15:0] ACCEPTED_CODE_RESET = 16'd200;

   // Result kinds
   localparam logic RESULT_KIND_TYPE_CHAR = 1'b0;
   localparam logic RESULT_KIND_SUMMARY   = 1'b1;

   // Parse status codes of the summary
   localparam logic [1:0] PARSE_STATUS_ACCEPTED       = 2'd0;
   localparam logic [1:0] PARSE_STATUS_NO_STATUS_LINE = 2'd1;
   localparam logic [1:0] PARSE_STATUS_NOT_ACCEPTED   = 2'd2;

   // Fixed-width part of one result transaction; the length follows it
   typedef struct packed {
      logic        result_kind;
      logic [7:0]  type_char;
      logic [1:0]  parse_status;
      logic [15:0] response_code;
      logic        length_present;
      logic        type_present;
      logic        last_result;
   } result_head_type;

   localparam int HEAD_BITS = $bits(result_head_type);

   // Results raised by one header byte
   typedef struct packed {
      logic char_valid;
      logic summary_valid;
   } push_type;

   // "HTTP"
   function automatic logic [7:0] http_pattern(input logic [1:0] pos);
      logic [7:0] c;
      case (pos)
         2'd0:    c = "H";
         2'd1:    c = "T";
         2'd2:    c = "T";
         default: c = "P";
      endcase
      return c;
   endfunction

   // "Content-Length: "
   function automatic logic [7:0] length_pattern(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = "C";
         4'd1:    c = "o";
         4'd2:    c = "n";
         4'd3:    c = "t";
         4'd4:    c = "e";
         4'd5:    c = "n";
         4'd6:    c = "t";
         4'd7:    c = "-";
         4'd8:    c = "L";
         4'd9:    c = "e";
         4'd10:   c = "n";
         4'd11:   c = "g";
         4'd12:   c = "t";
         4'd13:   c = "h";
         4'd14:   c = ":";
         default: c = " ";
      endcase
      return c;
   endfunction

   // "Content-Type: "
   function automatic logic [7:0] type_pattern(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = "C";
         4'd1:    c = "o";
         4'd2:    c = "n";
         4'd3:    c = "t";
         4'd4:    c = "e";
         4'd5:    c = "n";
         4'd6:    c = "t";
         4'd7:    c = "-";
         4'd8:    c = "T";
         4'd9:    c = "y";
         4'd10:   c = "p";
         4'd11:   c = "e";
         4'd12:   c = ":";
         4'd13:   c = " ";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

@@ rtl/hrhe_if.sv @@
// ----------------------------------------------------------------------------
// hrhe_if
// Valid/ready channels of the HTTP response header extractor: header bytes
// in, content type characters and summaries out.
// ----------------------------------------------------------------------------
interface hrhe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_text;

   modport source (output valid, output data_byte, output end_of_text, input ready);
   modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface hrhe_rsp_if #(
   parameter int LENGTH_BITS = 48
);
   logic                   valid;
   logic                   ready;
   logic                   result_kind;
   logic [7:0]             type_char;
   logic [1:0]             parse_status;
   logic [15:0]            response_code;
   logic [LENGTH_BITS-1:0] content_length;
   logic                   length_present;
   logic                   type_present;
   logic                   last_result;

   modport source (
      output valid, output result_kind, output type_char, output parse_status,
      output response_code, output content_length, output length_present,
      output type_present, output last_result, input ready
   );
   modport sink (
      input valid, input result_kind, input type_char, input parse_status,
      input response_code, input content_length, input length_present,
      input type_present, input last_result, output ready
   );
endinterface

@@ rtl/http_response_header_extractor_unit.sv @@
// ----------------------------------------------------------------------------
// http_response_header_extractor_unit
// Reads HTTP response header text one byte per transaction. It finds the
// status line whose code equals the accepted code (csr_write_data, reset
// 200), emits each Content-Type value character as a result, and on the byte
// marked end_of_text emits a summary with status, code, Content-Length and
// presence flags, then starts afresh. One byte is accepted every cycle while
// the queue has room for two results; a byte yields zero, one or two results
// (two only for a final byte that also carries a content type character).
// Results pass the input register, then a four-entry queue, and the result
// side delivers one per cycle from the queue while the receiver is ready.
// ----------------------------------------------------------------------------
module http_response_header_extractor_unit #(
   parameter int LENGTH_BITS = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   hrhe_req_if.sink    req_chan,
   hrhe_rsp_if.source  rsp_chan
);

   localparam int QueueDepth = 4;
   localparam int EntryBits  = hrhe_pkg::HEAD_BITS + LENGTH_BITS;

   logic [15:0]               accepted_code_ff;
   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                in_byte_ff;
   logic                      in_last_ff;
   logic                      req_fire;
   logic                      advance;
   logic                      room_for_two;
   logic                      queue_not_empty;
   hrhe_pkg::push_type        push;
   logic [EntryBits-1:0]      char_entry;
   logic [EntryBits-1:0]      summary_entry;
   logic [EntryBits-1:0]      head_data;
   hrhe_pkg::result_head_type head;

   // Hold the accepted status code
   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_code_ff <= hrhe_pkg::ACCEPTED_CODE_RESET;
      end else if (csr_write_enable) begin
         accepted_code_ff <= csr_write_data;
      end
   end

   // Input register: take a byte when it is empty or the held one moves on
   assign advance        = in_valid_ff && room_for_two;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign in_valid_in    = req_fire || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.end_of_text;
      end
   end

   hrhe_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .data_byte     (in_byte_ff),
      .end_of_text   (in_last_ff),
      .accepted_code (accepted_code_ff),
      .push          (push),
      .char_entry    (char_entry),
      .summary_entry (summary_entry)
   );

   hrhe_result_queue #(
      .DATA_BITS (EntryBits),
      .DEPTH     (QueueDepth)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_a       (push.char_valid),
      .data_a       (char_entry),
      .push_b       (push.summary_valid),
      .data_b       (summary_entry),
      .pop          (rsp_chan.ready),
      .head_data    (head_data),
      .not_empty    (queue_not_empty),
      .room_for_two (room_for_two)
   );

   // Unpack the queue head onto the result channel
   assign head                    = hrhe_pkg::result_head_type'(head_data[EntryBits-1:LENGTH_BITS]);
   assign rsp_chan.valid          = queue_not_empty;
   assign rsp_chan.result_kind    = head.result_kind;
   assign rsp_chan.type_char      = head.type_char;
   assign rsp_chan.parse_status   = head.parse_status;
   assign rsp_chan.response_code  = head.response_code;
   assign rsp_chan.content_length = head_data[LENGTH_BITS-1:0];
   assign rsp_chan.length_present = head.length_present;
   assign rsp_chan.type_present   = head.type_present;
   assign rsp_chan.last_result    = head.last_result;

   // Content type characters only come from an accepted response
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.result_kind == hrhe_pkg::RESULT_KIND_TYPE_CHAR))
      |-> ((rsp_chan.parse_status == hrhe_pkg::PARSE_STATUS_ACCEPTED) && !rsp_chan.last_result))
      else $error("content type character carries summary fields");

   // A summary without a status line reports no code and no fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.result_kind == hrhe_pkg::RESULT_KIND_SUMMARY)
       && (rsp_chan.parse_status == hrhe_pkg::PARSE_STATUS_NO_STATUS_LINE))
      |-> ((rsp_chan.response_code == 16'd0) && !rsp_chan.length_present
           && !rsp_chan.type_present))
      else $error("summary without status line reports fields");

   // A byte that cannot move on stays in the input register
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff)))
      else $error("held header byte lost");

   // The input side stalls only behind a held byte
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (in_valid_ff && !room_for_two))
      else $error("input stalled without cause");

endmodule

@@ rtl/hrhe_parser.sv @@
// ----------------------------------------------------------------------------
// hrhe_parser
// Byte-wise parser state: status line search, status code, Content-Length
// value and Content-Type value. Raises up to two results per byte.
// ----------------------------------------------------------------------------
module hrhe_parser #(
   parameter int LENGTH_BITS = 48
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     step,
   input  logic [7:0]                               data_byte,
   input  logic                                     end_of_text,
   input  logic [15:0]                              accepted_code,
   output hrhe_pkg::push_type                       push,
   output logic [hrhe_pkg::HEAD_BITS+LENGTH_BITS-1:0] char_entry,
   output logic [hrhe_pkg::HEAD_BITS+LENGTH_BITS-1:0] summary_entry
);

   typedef enum logic [1:0] {
      PH_FIND_HTTP,
      PH_FIND_SPACE,
      PH_READ_CODE,
      PH_ACCEPTED
   } phase_type;

   typedef enum logic [1:0] {
      SUB_SEARCH,
      SUB_ACTIVE,
      SUB_DONE
   } sub_type;

   phase_type              phase_ff, phase_in;
   logic [1:0]             http_pos_ff, http_pos_in;
   logic                   status_seen_ff, status_seen_in;
   logic [15:0]            code_ff, code_in;
   logic [3:0]             len_pos_ff, len_pos_in;
   logic [LENGTH_BITS-1:0] len_acc_ff, len_acc_in;
   sub_type                len_phase_ff, len_phase_in;
   logic [3:0]             type_pos_ff, type_pos_in;
   sub_type                type_phase_ff, type_phase_in;

   logic                   is_digit;
   logic [7:0]             digit_diff;
   logic [3:0]             digit;
   logic [19:0]            code_wide;
   logic [15:0]            code_step;
   logic [LENGTH_BITS+3:0] len_wide;
   logic [LENGTH_BITS-1:0] len_step;
   logic [1:0]             http_restart;
   logic                   feed_fields;
   logic                   type_end;
   logic                   char_fire;
   logic                   summary_ok;
   hrhe_pkg::result_head_type char_head, summary_head;
   logic [LENGTH_BITS-1:0] summary_length;

   // Decode the byte as a decimal digit
   assign is_digit   = (data_byte >= hrhe_pkg::CHAR_ZERO) && (data_byte <= hrhe_pkg::CHAR_NINE);
   assign digit_diff = data_byte - hrhe_pkg::CHAR_ZERO;
   assign digit      = digit_diff[3:0];

   // Status code times ten plus digit, saturating at 16 bits
   assign code_wide = ({4'b0, code_ff} << 3) + ({4'b0, code_ff} << 1) + {16'b0, digit};
   assign code_step = (|code_wide[19:16]) ? 16'hFFFF : code_wide[15:0];

   // Content length times ten plus digit, saturating at the length width
   assign len_wide = ({4'b0, len_acc_ff} << 3) + ({4'b0, len_acc_ff} << 1)
                   + {{LENGTH_BITS{1'b0}}, digit};
   assign len_step = (|len_wide[LENGTH_BITS+3:LENGTH_BITS]) ? {LENGTH_BITS{1'b1}}
                                                             : len_wide[LENGTH_BITS-1:0];

   // Restart the marker search on a mismatch; no marker has a proper border
   assign http_restart = (data_byte == hrhe_pkg::CHAR_H) ? 2'd1 : 2'd0;

   assign type_end = (data_byte == hrhe_pkg::CHAR_CR) || (data_byte == hrhe_pkg::CHAR_LF)
                  || (data_byte == hrhe_pkg::CHAR_SEMI) || (data_byte == hrhe_pkg::CHAR_COMMA)
                  || (data_byte == hrhe_pkg::CHAR_NUL);

   // Status line tracking
   always_comb begin
      phase_in       = phase_ff;
      http_pos_in    = http_pos_ff;
      status_seen_in = status_seen_ff;
      code_in        = code_ff;
      feed_fields    = 1'b0;
      unique case (phase_ff)
         PH_FIND_HTTP: begin
            if (data_byte == hrhe_pkg::http_pattern(http_pos_ff)) begin
               if (http_pos_ff == hrhe_pkg::HTTP_LAST_POS) begin
                  http_pos_in = 2'd0;
                  phase_in    = PH_FIND_SPACE;
               end else begin
                  http_pos_in = http_pos_ff + 2'd1;
               end
            end else begin
               http_pos_in = http_restart;
            end
         end
         PH_FIND_SPACE: begin
            if (data_byte == hrhe_pkg::CHAR_SPACE) begin
               status_seen_in = 1'b1;
               code_in        = 16'd0;
               phase_in       = PH_READ_CODE;
            end
         end
         PH_READ_CODE: begin
            if (is_digit) begin
               code_in = code_step;
            end else if (code_ff == accepted_code) begin
               phase_in    = PH_ACCEPTED;
               feed_fields = 1'b1;
            end else begin
               phase_in    = PH_FIND_HTTP;
               http_pos_in = http_restart;
            end
         end
         PH_ACCEPTED: begin
            feed_fields = 1'b1;
         end
      endcase
   end

   // Field matchers of the accepted response
   always_comb begin
      len_pos_in    = len_pos_ff;
      len_acc_in    = len_acc_ff;
      len_phase_in  = len_phase_ff;
      type_pos_in   = type_pos_ff;
      type_phase_in = type_phase_ff;
      char_fire     = 1'b0;
      if (feed_fields) begin
         if (len_phase_ff == SUB_SEARCH) begin
            if (data_byte == hrhe_pkg::length_pattern(len_pos_ff)) begin
               len_pos_in = len_pos_ff + 4'd1;
               if (len_pos_ff == hrhe_pkg::LENGTH_LAST_POS) begin
                  len_phase_in = SUB_ACTIVE;
                  len_acc_in   = '0;
               end
            end else begin
               len_pos_in = (data_byte == hrhe_pkg::CHAR_C) ? 4'd1 : 4'd0;
            end
         end else if (len_phase_ff == SUB_ACTIVE) begin
            if (is_digit) begin
               len_acc_in = len_step;
            end else begin
               len_phase_in = SUB_DONE;
            end
         end

         if (type_phase_ff == SUB_SEARCH) begin
            if (data_byte == hrhe_pkg::type_pattern(type_pos_ff)) begin
               type_pos_in = type_pos_ff + 4'd1;
               if (type_pos_ff == hrhe_pkg::TYPE_LAST_POS) begin
                  type_phase_in = SUB_ACTIVE;
               end
            end else begin
               type_pos_in = (data_byte == hrhe_pkg::CHAR_C) ? 4'd1 : 4'd0;
            end
         end else if (type_phase_ff == SUB_ACTIVE) begin
            if (type_end) begin
               type_phase_in = SUB_DONE;
            end else begin
               char_fire = 1'b1;
            end
         end
      end
   end

   // Build the content type character result
   always_comb begin
      char_head                = '0;
      char_head.result_kind    = hrhe_pkg::RESULT_KIND_TYPE_CHAR;
      char_head.type_char      = data_byte;
      char_entry               = {char_head, {LENGTH_BITS{1'b0}}};
   end

   // Build the summary from the state after this byte
   always_comb begin
      summary_ok = (phase_in == PH_ACCEPTED)
                || ((phase_in == PH_READ_CODE) && (code_in == accepted_code));
      summary_head               = '0;
      summary_head.result_kind   = hrhe_pkg::RESULT_KIND_SUMMARY;
      summary_head.last_result   = 1'b1;
      summary_head.response_code = status_seen_in ? code_in : 16'd0;
      summary_length             = '0;
      if (summary_ok) begin
         summary_head.parse_status = hrhe_pkg::PARSE_STATUS_ACCEPTED;
         if ((phase_in == PH_ACCEPTED) && (len_phase_in != SUB_SEARCH)) begin
            summary_head.length_present = 1'b1;
            summary_length              = len_acc_in;
         end
         summary_head.type_present = (phase_in == PH_ACCEPTED) && (type_phase_in != SUB_SEARCH);
      end else if (status_seen_in) begin
         summary_head.parse_status = hrhe_pkg::PARSE_STATUS_NOT_ACCEPTED;
      end else begin
         summary_head.parse_status = hrhe_pkg::PARSE_STATUS_NO_STATUS_LINE;
      end
      summary_entry = {summary_head, summary_length};
   end

   assign push.char_valid    = step && char_fire;
   assign push.summary_valid = step && end_of_text;

   // Hold state; advance on each byte and clear after the summary
   always_ff @(posedge clock) begin
      if (reset || (step && end_of_text)) begin
         phase_ff       <= PH_FIND_HTTP;
         http_pos_ff    <= 2'd0;
         status_seen_ff <= 1'b0;
         code_ff        <= 16'd0;
         len_pos_ff     <= 4'd0;
         len_acc_ff     <= '0;
         len_phase_ff   <= SUB_SEARCH;
         type_pos_ff    <= 4'd0;
         type_phase_ff  <= SUB_SEARCH;
      end else if (step) begin
         phase_ff       <= phase_in;
         http_pos_ff    <= http_pos_in;
         status_seen_ff <= status_seen_in;
         code_ff        <= code_in;
         len_pos_ff     <= len_pos_in;
         len_acc_ff     <= len_acc_in;
         len_phase_ff   <= len_phase_in;
         type_pos_ff    <= type_pos_in;
         type_phase_ff  <= type_phase_in;
      end
   end

endmodule

@@ rtl/hrhe_result_queue.sv @@
// ----------------------------------------------------------------------------
// hrhe_result_queue
// Small result queue: takes up to two transactions per cycle, in order, and
// hands out one per cycle while pop is high.
// ----------------------------------------------------------------------------
module hrhe_result_queue #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_a,
   input  logic [DATA_BITS-1:0] data_a,
   input  logic                 push_b,
   input  logic [DATA_BITS-1:0] data_b,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] head_data,
   output logic                 not_empty,
   output logic                 room_for_two
);

   localparam int PtrBits   = $clog2(DEPTH);
   localparam int CountBits = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0] entries_ff [DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic [PtrBits-1:0]   wr_ptr_b;
   logic                 pop_ok;

   assign not_empty    = (count_ff != '0);
   assign room_for_two = (count_ff <= CountBits'(DEPTH - 2));
   assign head_data    = entries_ff[rd_ptr_ff];
   assign pop_ok       = pop && not_empty;
   assign wr_ptr_b     = push_a ? (wr_ptr_ff + PtrBits'(1)) : wr_ptr_ff;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrBits'(push_a) + PtrBits'(push_b);
      rd_ptr_in = rd_ptr_ff + PtrBits'(pop_ok);
      count_in  = count_ff + CountBits'(push_a) + CountBits'(push_b) - CountBits'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write storage; the character goes ahead of the summary
   always_ff @(posedge clock) begin
      if (push_a) begin
         entries_ff[wr_ptr_ff] <= data_a;
      end
      if (push_b) begin
         entries_ff[wr_ptr_b] <= data_b;
      end
   end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the HTTP response header extractor. Header texts
// go in one byte per transaction, with bursts and gaps on the input side
// and a stalling receiver on the result side. An internal predictor works
// out the content type characters and the summary of each text. Every
// result that arrives is compared field by field with the oldest
// prediction. Directed texts cover the status and field corner cases, then
// random well-formed responses and noise run under several accepted codes.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          LENGTH_BITS  = 48;
   localparam logic [63:0] LENGTH_MAX   = (64'd1 << LENGTH_BITS) - 64'd1;
   localparam int unsigned RANDOM_BYTES = 1000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT  = 500000;

   // Markers, right-justified; the first character sits in the top byte used
   localparam logic [127:0] STATUS_MARKER = "HTTP";
   localparam logic [127:0] LENGTH_MARKER = "Content-Length: ";
   localparam logic [127:0] TYPE_MARKER   = "Content-Type: ";
   localparam int unsigned  STATUS_MARKER_LEN = 4;
   localparam int unsigned  LENGTH_MARKER_LEN = 16;
   localparam int unsigned  TYPE_MARKER_LEN   = 14;

   typedef enum logic [1:0] {
      SEEK_MARKER, SEEK_SPACE, READ_CODE, IN_RESPONSE
   } line_phase_type;

   typedef enum logic [1:0] {
      FIELD_SEARCH, FIELD_ACTIVE, FIELD_DONE
   } field_phase_type;

   typedef struct packed {
      logic                   kind;
      logic [7:0]             tchar;
      logic [1:0]             status;
      logic [15:0]            code;
      logic [LENGTH_BITS-1:0] length;
      logic                   len_present;
      logic                   type_present;
      logic                   last;
   } extract_result_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;

   hrhe_req_if req_bus ();
   hrhe_rsp_if #(.LENGTH_BITS(LENGTH_BITS)) rsp_bus ();

   http_response_header_extractor_unit #(
      .LENGTH_BITS(LENGTH_BITS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus)
   );

   // Predicted extractor state
   logic [15:0]      accepted_code_model;
   line_phase_type   line_phase;
   logic [4:0]       status_pos;
   logic             status_seen;
   logic [15:0]      code_acc;
   logic [4:0]       length_pos;
   logic [63:0]      length_acc;
   field_phase_type  length_phase;
   logic [4:0]       type_pos;
   field_phase_type  type_phase;

   extract_result_type pending_results[$];
   logic [7:0]         text_bytes[$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned burst_left     = 0;
   int unsigned stall_left     = 0;
   bit          gaps_on        = 1'b0;
   bit          stalls_on      = 1'b0;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic logic [4:0] marker_advance(input logic [4:0] pos,
                                                 input logic [127:0] marker,
                                                 input int unsigned mlen,
                                                 input logic [7:0] b);
      logic [7:0] lead_char;
      logic [7:0] next_char;
      lead_char = marker[(mlen-1)*8 +: 8];
      next_char = (pos < mlen) ? marker[(mlen-1-pos)*8 +: 8] : 8'h00;
      if (pos < mlen && b == next_char)
         return pos + 5'd1;
      return (b == lead_char) ? 5'd1 : 5'd0;
   endfunction

   function automatic bit is_decimal_digit(input logic [7:0] b);
      return b >= hrhe_pkg::CHAR_ZERO && b <= hrhe_pkg::CHAR_NINE;
   endfunction

   function automatic void clear_parse_state();
      line_phase   = SEEK_MARKER;
      status_pos   = '0;
      status_seen  = 1'b0;
      code_acc     = '0;
      length_pos   = '0;
      length_acc   = '0;
      length_phase = FIELD_SEARCH;
      type_pos     = '0;
      type_phase   = FIELD_SEARCH;
   endfunction

   // Run both field matchers over one byte of the accepted response
   task automatic scan_header_fields(input logic [7:0] b);
      extract_result_type r;
      logic [63:0]        d;
      case (length_phase)
         FIELD_SEARCH: begin
            length_pos = marker_advance(length_pos, LENGTH_MARKER, LENGTH_MARKER_LEN, b);
            if (length_pos == LENGTH_MARKER_LEN) begin
               length_phase = FIELD_ACTIVE;
               length_acc   = '0;
            end
         end
         FIELD_ACTIVE: begin
            if (is_decimal_digit(b)) begin
               d = 64'(b - hrhe_pkg::CHAR_ZERO);
               if (length_acc > (LENGTH_MAX - d) / 64'd10)
                  length_acc = LENGTH_MAX;
               else
                  length_acc = length_acc * 64'd10 + d;
            end else begin
               length_phase = FIELD_DONE;
            end
         end
         default: ;
      endcase

      case (type_phase)
         FIELD_SEARCH: begin
            type_pos = marker_advance(type_pos, TYPE_MARKER, TYPE_MARKER_LEN, b);
            if (type_pos == TYPE_MARKER_LEN)
               type_phase = FIELD_ACTIVE;
         end
         FIELD_ACTIVE: begin
            if (b == hrhe_pkg::CHAR_CR || b == hrhe_pkg::CHAR_LF ||
                b == hrhe_pkg::CHAR_SEMI || b == hrhe_pkg::CHAR_COMMA ||
                b == hrhe_pkg::CHAR_NUL) begin
               type_phase = FIELD_DONE;
            end else begin
               r       = '0;
               r.kind  = hrhe_pkg::RESULT_KIND_TYPE_CHAR;
               r.tchar = b;
               pending_results.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   // Advance the prediction by one accepted header byte
   task automatic predict_header_byte(input logic [7:0] b, input logic eot);
      extract_result_type r;
      logic [31:0]        v;
      bit                 ok;
      case (line_phase)
         SEEK_MARKER: begin
            status_pos = marker_advance(status_pos, STATUS_MARKER, STATUS_MARKER_LEN, b);
            if (status_pos == STATUS_MARKER_LEN) begin
               status_pos = '0;
               line_phase = SEEK_SPACE;
            end
         end
         SEEK_SPACE: begin
            if (b == hrhe_pkg::CHAR_SPACE) begin
               status_seen = 1'b1;
               code_acc    = '0;
               line_phase  = READ_CODE;
            end
         end
         READ_CODE: begin
            if (is_decimal_digit(b)) begin
               v        = 32'(code_acc) * 32'd10 + 32'(b - hrhe_pkg::CHAR_ZERO);
               code_acc = (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
            end else if (code_acc == accepted_code_model) begin
               line_phase = IN_RESPONSE;
               scan_header_fields(b);
            end else begin
               // Look for the next status line from this very byte
               line_phase = SEEK_MARKER;
               status_pos = marker_advance(5'd0, STATUS_MARKER, STATUS_MARKER_LEN, b);
            end
         end
         default: scan_header_fields(b);
      endcase

      if (eot) begin
         ok = (line_phase == IN_RESPONSE) ||
              (line_phase == READ_CODE && code_acc == accepted_code_model);
         r      = '0;
         r.kind = hrhe_pkg::RESULT_KIND_SUMMARY;
         r.code = code_acc;
         r.last = 1'b1;
         if (ok) begin
            r.status = hrhe_pkg::PARSE_STATUS_ACCEPTED;
            if (line_phase == IN_RESPONSE && length_phase != FIELD_SEARCH) begin
               r.length      = length_acc[LENGTH_BITS-1:0];
               r.len_present = 1'b1;
            end
            if (line_phase == IN_RESPONSE && type_phase != FIELD_SEARCH)
               r.type_present = 1'b1;
         end else begin
            r.status = status_seen ? hrhe_pkg::PARSE_STATUS_NOT_ACCEPTED
                                   : hrhe_pkg::PARSE_STATUS_NO_STATUS_LINE;
            if (!status_seen)
               r.code = '0;
         end
         pending_results.push_back(r);
         clear_parse_state();
      end
   endtask

   // ------------------------------------------------------------------------
   // Clock, stalling receiver, result checker, cycle limit
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hold ready low and high for runs of random length while stalls are on
   always @(posedge clock) begin : result_stall
      if (!stalls_on) begin
         rsp_bus.ready <= 1'b1;
      end else if (stall_left == 0) begin
         if (rsp_bus.ready) begin
            rsp_bus.ready <= 1'b0;
            stall_left = $urandom_range(1, 6);
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = $urandom_range(1, 8);
         end
      end else begin
         stall_left--;
      end
   end

   task automatic check_field(input string field_name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field_name, want, got);
         mismatch_count++;
      end
   endtask

   // Compare each result transaction with the oldest prediction
   always @(posedge clock) begin : result_checker
      extract_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual kind %0d char %0h",
                     $time, rsp_bus.result_kind, rsp_bus.type_char);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("result_kind", 64'(want.kind), 64'(rsp_bus.result_kind));
            check_field("type_char", 64'(want.tchar), 64'(rsp_bus.type_char));
            check_field("parse_status", 64'(want.status), 64'(rsp_bus.parse_status));
            check_field("response_code", 64'(want.code), 64'(rsp_bus.response_code));
            check_field("content_length", 64'(want.length), 64'(rsp_bus.content_length));
            check_field("length_present", 64'(want.len_present),
                        64'(rsp_bus.length_present));
            check_field("type_present", 64'(want.type_present), 64'(rsp_bus.type_present));
            check_field("last_result", 64'(want.last), 64'(rsp_bus.last_result));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------
   // Offer one byte, with a random gap at the start of each burst
   task automatic send_header_byte(input logic [7:0] b, input logic eot);
      int unsigned gap;
      if (gaps_on && burst_left == 0) begin
         gap        = $urandom_range(0, 5);
         burst_left = $urandom_range(1, 12);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left != 0)
         burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= b;
      req_bus.end_of_text <= eot;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_header_byte(b, eot);
   endtask

   task automatic send_queued_text();
      for (int i = 0; i < text_bytes.size(); i++)
         send_header_byte(text_bytes[i], i == text_bytes.size() - 1);
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++)
         text_bytes.push_back(s[i]);
   endtask

   task automatic send_text(input string s);
      text_bytes.delete();
      add_str(s);
      send_queued_text();
   endtask

   // Drop valid and let every predicted result and any byte in flight drain
   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_accepted_code(input logic [15:0] code);
      wait_until_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= code;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      accepted_code_model = code;
   endtask

   // ------------------------------------------------------------------------
   // Random text building
   // ------------------------------------------------------------------------
   task automatic add_noise(input int unsigned n);
      string alphabet;
      alphabet = "HTTP 0123456789:-Cont\015\n";
      repeat (n) begin
         if ($urandom_range(0, 1) == 0)
            text_bytes.push_back(8'($urandom_range(0, 255)));
         else
            text_bytes.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
      end
   endtask

   task automatic add_digits(input int unsigned n);
      repeat (n) text_bytes.push_back(hrhe_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
   endtask

   function automatic string accepted_code_text();
      string dec;
      dec = $sformatf("%0d", accepted_code_model);
      case ($urandom_range(0, 5))
         0:       return {"0", dec};
         1:       return (accepted_code_model == 16'd0) ? "" : dec;
         2:       return (accepted_code_model == 16'hFFFF) ? "123456" : dec;
         3:       return $sformatf("%0d", $urandom_range(0, 999));
         default: return dec;
      endcase
   endfunction

   // "\015" is CR throughout
   task automatic add_status_line(input string code);
      add_str("HTTP/1.");
      text_bytes.push_back(hrhe_pkg::CHAR_ZERO + 8'($urandom_range(0, 1)));
      add_str(" ");
      add_str(code);
      add_str($urandom_range(0, 1) ? " OK\015\n" : "\015\n");
   endtask

   task automatic add_headers(input int unsigned n);
      string token_chars;
      token_chars = "abcdefghijklmnopqrstuvwxyz/+-.=";
      repeat (n) begin
         case ($urandom_range(0, 7))
            0, 1: begin
               add_str("Content-Length: ");
               case ($urandom_range(0, 5))
                  0:       add_digits($urandom_range(1, 20));
                  1:       ;
                  2:       add_str("281474976710655");
                  3:       add_str("281474976710656");
                  default: add_str($sformatf("%0d", $urandom_range(0, 99999)));
               endcase
               if ($urandom_range(0, 3) == 0)
                  add_noise(1);
               add_str("\015\n");
            end
            2, 3: begin
               add_str("Content-Type: ");
               repeat ($urandom_range(0, 10)) begin
                  if ($urandom_range(0, 7) == 0)
                     text_bytes.push_back(8'($urandom_range(0, 255)));
                  else
                     text_bytes.push_back(token_chars[$urandom_range(0, token_chars.len() - 1)]);
               end
               case ($urandom_range(0, 4))
                  0: text_bytes.push_back(hrhe_pkg::CHAR_LF);
                  1: add_str("; charset=utf-8\015\n");
                  2: add_str(", x\015\n");
                  3: begin
                     text_bytes.push_back(hrhe_pkg::CHAR_NUL);
                     add_str("z\015\n");
                  end
                  default: add_str("\015\n");
               endcase
            end
            4: add_str("Server: unit-test\015\n");
            5: add_str("X-Note: HTTP 404 inside\015\n");
            6: begin
               case ($urandom_range(0, 3))
                  0:       add_str("Content-Lengt: 9");
                  1:       add_str("Content-Typ: q");
                  2:       add_str("CContent-Length:7");
                  default: add_str("Content-");
               endcase
               add_str("\015\n");
            end
            default: add_noise($urandom_range(1, 6));
         endcase
      end
   endtask

   task automatic build_random_response();
      int unsigned cut;
      text_bytes.delete();
      if ($urandom_range(0, 3) == 0)
         add_noise($urandom_range(1, 10));
      // Sometimes an interim or rejected response comes first
      if ($urandom_range(0, 2) == 0) begin
         add_status_line($sformatf("%0d", $urandom_range(100, 599)));
         add_headers($urandom_range(0, 2));
         add_str("\015\n");
      end
      add_status_line(accepted_code_text());
      add_headers($urandom_range(0, 5));
      add_str("\015\n");
      // End the text early now and then, anywhere in it
      if ($urandom_range(0, 4) == 0) begin
         cut        = $urandom_range(1, text_bytes.size());
         text_bytes = text_bytes[0:cut-1];
      end
   endtask

   function automatic logic [15:0] pick_accepted_code();
      case ($urandom_range(0, 6))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'd404;
         3:       return 16'($urandom_range(0, 999));
         4:       return 16'($urandom_range(0, 65535));
         default: return hrhe_pkg::ACCEPTED_CODE_RESET;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_accepted_response();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      send_text({"HTTP/1.1 200 OK\015\nContent-Type: text/html; charset=utf-8\015\n",
                 "Content-Length: 1234\015\n\015\n"});
      gaps_on = 1'b1;
      send_text("HTTP/1.1 200 OK\015\nContent-Length: 281474976710655\015\nContent-Type: a,b\n");
      stalls_on = 1'b1;
      send_text("HTTP/1.1 200 OK\015\nContent-Length: 99999999999999999999\015\n");
   endtask

   task automatic test_missing_status_line();
      send_text("no status here\015\n");
      // Marker with no space before the end
      send_text("xHTTP/1.1");
      send_header_byte(8'hFF, 1'b1);
      send_header_byte(8'h00, 1'b1);
   endtask

   task automatic test_rejected_status();
      send_text("HTTP/1.1 404 Not Found\015\nContent-Length: 7\015\n");
      send_text({"HTTP/1.1 100 Continue\015\n\015\nHTTP/1.1 200 OK\015\n",
                 "Content-Type: x/y\n"});
      // Ends inside the digits of a code that is not accepted
      send_text("HTTP/1.1 301");
   endtask

   task automatic test_code_edges();
      set_accepted_code(16'd0);
      // Space without digits reads as code zero
      send_text("HTTP/1.1 OK\015\nContent-Length: 5\015\n");
      set_accepted_code(16'hFFFF);
      send_text("HTTP/2 99999 X\015\nContent-Type: big\015\n");
      set_accepted_code(16'd20);
      send_text("HTTP/1.0 20");
      set_accepted_code(hrhe_pkg::ACCEPTED_CODE_RESET);
   endtask

   task automatic test_field_values();
      send_text("HTTP/1.1 200 OK\015\nContent-Length: \015\nContent-Type: ;x\015\n");
      // Zero byte is ordinary text except inside the type value
      text_bytes.delete();
      add_str("HTTP/1.1 200 OK\015\nX-Pad: ");
      text_bytes.push_back(hrhe_pkg::CHAR_NUL);
      add_str("\015\nContent-Type: ab");
      text_bytes.push_back(hrhe_pkg::CHAR_NUL);
      add_str("cd\015\n");
      send_queued_text();
      text_bytes.delete();
      add_str("HTTP/1.1 200 OK\015\nContent-Type: x");
      text_bytes.push_back(8'hFF);
      text_bytes.push_back(8'h80);
      add_str("\015\n");
      send_queued_text();
      // Final byte carries a type character as well as the summary
      send_text("HTTP 200 Content-Type: q");
   endtask

   task automatic test_random_headers();
      int unsigned bytes_sent;
      int unsigned texts;
      bytes_sent = 0;
      texts      = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         if (texts % 8 == 0)
            set_accepted_code(pick_accepted_code());
         gaps_on   = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) == 0) begin
            text_bytes.delete();
            add_noise($urandom_range(1, 40));
         end else begin
            build_random_response();
         end
         bytes_sent += text_bytes.size();
         send_queued_text();
         texts++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      req_bus.valid       = 1'b0;
      req_bus.data_byte   = '0;
      req_bus.end_of_text = 1'b0;
      rsp_bus.ready       = 1'b0;
      accepted_code_model = hrhe_pkg::ACCEPTED_CODE_RESET;
      clear_parse_state();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_accepted_response();
      test_missing_status_line();
      test_rejected_status();
      test_code_edges();
      test_field_values();
      test_random_headers();
      wait_until_drained();

      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ files.f @@
rtl/hrhe_pkg.sv
rtl/hrhe_if.sv
rtl/hrhe_parser.sv
rtl/hrhe_result_queue.sv
rtl/http_response_header_extractor_unit.sv
tb/sv/testbench.sv
